### sv/fpbq_pkg.sv
`default_nettype none

package fpbq_pkg;

   localparam int SampleWidth = 32;
   localparam int AccWidth    = 64;
   localparam int ErrWidth    = 30;
   localparam int CsrAddrWidth = 5;
   localparam int CsrDataWidth = 32;

   typedef logic signed [SampleWidth-1:0] sample_type;
   typedef logic signed [AccWidth-1:0]    acc_type;
   typedef logic        [ErrWidth-1:0]    err_type;

   // register index, taken from csr address bits [4:2]
   typedef enum logic [2:0] {
      REG_COEF_B0       = 3'd0,
      REG_COEF_B1       = 3'd1,
      REG_COEF_B2       = 3'd2,
      REG_COEF_A1       = 3'd3,
      REG_COEF_A2       = 3'd4,
      REG_NOISE_SHAPING = 3'd5
   } reg_index_type;

   localparam acc_type AccMax   = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam acc_type AccMin   = 64'sh8000_0000_0000_0000;
   localparam acc_type RoundBit = 64'sh0000_0000_8000_0000;

   // signed 64-bit add, clamped to the 64-bit range
   function automatic acc_type sat_add64(input acc_type a, input acc_type b);
      logic signed [AccWidth:0] s;
      s = {a[AccWidth-1], a} + {b[AccWidth-1], b};
      if (s[AccWidth] != s[AccWidth-1]) begin
         sat_add64 = s[AccWidth] ? AccMin : AccMax;
      end else begin
         sat_add64 = s[AccWidth-1:0];
      end
   endfunction

   // left shift by two, clamped to the 64-bit range
   function automatic acc_type sat_shl2(input acc_type v);
      if (v[AccWidth-1:AccWidth-3] == 3'b000 || v[AccWidth-1:AccWidth-3] == 3'b111) begin
         sat_shl2 = {v[AccWidth-3:0], 2'b00};
      end else begin
         sat_shl2 = v[AccWidth-1] ? AccMin : AccMax;
      end
   endfunction

endpackage

`default_nettype wire

### sv/fixed_point_biquad_noise_shaped_core.sv
// direct form I biquad with optional first-order error feedback
//
// req channel: one signed Q31 sample per transfer on req_tdata
// rsp channel: one signed Q31 filtered sample per transfer on rsp_tdata
// csr port: APB-style, registers at byte address 4*i: coef_b0, coef_b1,
//   coef_b2, coef_a1, coef_a2 (Q30, pre-halved), noise_shaping (bit 0);
//   write only while the filter is idle; pready is tied high
//
// a sample lands in the input register, then five parallel 32x32 products
// are summed with saturation, shifted left by 2, rounded (or truncated when
// noise shaping is on) into the result register, which drives rsp_tvalid
// and rsp_tdata; one sample per cycle sustained while rsp_tready stays high,
// limited by the combinational product and sum path that also feeds y1 back
//
// reset clears the delay line, the error register, the coefficients and
// both valid flags. when rsp_tready is low the result holds and one more
// sample is taken into the input register before req_tready drops
`default_nettype none

module fixed_point_biquad_noise_shaped_core (
   input  wire logic        clock,
   input  wire logic        reset,
   // req channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] sample_in
   // rsp channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [31:0] sample_out
   // csr port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [fpbq_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  wire logic [fpbq_pkg::CsrDataWidth-1:0] csr_pwdata,
   output logic [fpbq_pkg::CsrDataWidth-1:0]      csr_prdata,
   output logic             csr_pready
);

   // configuration registers
   fpbq_pkg::sample_type coef_b0_ff, coef_b1_ff, coef_b2_ff, coef_a1_ff, coef_a2_ff;
   logic                 noise_shaping_ff;

   // input stage and result stage
   logic                 in_valid_ff;
   fpbq_pkg::sample_type x_ff;
   logic                 rsp_valid_ff;
   fpbq_pkg::sample_type rsp_data_ff;

   // filter state
   fpbq_pkg::sample_type x1_ff, x2_ff, y1_ff, y2_ff;
   fpbq_pkg::err_type    err_ff;

   logic                 advance;
   logic                 csr_write;
   fpbq_pkg::reg_index_type csr_index;

   fpbq_pkg::acc_type    prod_b0, prod_a1, prod_b1, prod_a2, prod_b2;
   fpbq_pkg::acc_type    acc_start, acc1, acc2, acc3, acc4, acc5;
   fpbq_pkg::acc_type    acc_shifted, acc_rounded;
   fpbq_pkg::sample_type y_in;

   // handshake: the input stage moves on whenever the result stage is free
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // csr decode
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = fpbq_pkg::reg_index_type'(csr_paddr[4:2]);

   always_comb begin
      unique case (csr_index)
         fpbq_pkg::REG_COEF_B0:       csr_prdata = coef_b0_ff;
         fpbq_pkg::REG_COEF_B1:       csr_prdata = coef_b1_ff;
         fpbq_pkg::REG_COEF_B2:       csr_prdata = coef_b2_ff;
         fpbq_pkg::REG_COEF_A1:       csr_prdata = coef_a1_ff;
         fpbq_pkg::REG_COEF_A2:       csr_prdata = coef_a2_ff;
         fpbq_pkg::REG_NOISE_SHAPING: csr_prdata = {31'd0, noise_shaping_ff};
         default:                     csr_prdata = '0;
      endcase
   end

   // five signed products, each fits in 64 bits
   assign prod_b0 = coef_b0_ff * x_ff;
   assign prod_a1 = coef_a1_ff * y1_ff;
   assign prod_b1 = coef_b1_ff * x1_ff;
   assign prod_a2 = coef_a2_ff * y2_ff;
   assign prod_b2 = coef_b2_ff * x2_ff;

   // saturating sum in fixed order: clamping makes the order matter
   assign acc_start = noise_shaping_ff ? fpbq_pkg::acc_type'({34'd0, err_ff}) : '0;
   assign acc1 = fpbq_pkg::sat_add64(acc_start, prod_b0);
   assign acc2 = fpbq_pkg::sat_add64(acc1, prod_a1);
   assign acc3 = fpbq_pkg::sat_add64(acc2, prod_b1);
   assign acc4 = fpbq_pkg::sat_add64(acc3, prod_a2);
   assign acc5 = fpbq_pkg::sat_add64(acc4, prod_b2);

   // undo the coefficient halving, then round or truncate to Q31
   assign acc_shifted = fpbq_pkg::sat_shl2(acc5);
   assign acc_rounded = fpbq_pkg::sat_add64(acc_shifted, fpbq_pkg::RoundBit);
   assign y_in = noise_shaping_ff ? acc_shifted[63:32] : acc_rounded[63:32];

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_b0_ff       <= '0;
         coef_b1_ff       <= '0;
         coef_b2_ff       <= '0;
         coef_a1_ff       <= '0;
         coef_a2_ff       <= '0;
         noise_shaping_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            fpbq_pkg::REG_COEF_B0:       coef_b0_ff       <= csr_pwdata;
            fpbq_pkg::REG_COEF_B1:       coef_b1_ff       <= csr_pwdata;
            fpbq_pkg::REG_COEF_B2:       coef_b2_ff       <= csr_pwdata;
            fpbq_pkg::REG_COEF_A1:       coef_a1_ff       <= csr_pwdata;
            fpbq_pkg::REG_COEF_A2:       coef_a2_ff       <= csr_pwdata;
            fpbq_pkg::REG_NOISE_SHAPING: noise_shaping_ff <= csr_pwdata[0];
            default: ;  // addresses past the last register are ignored
         endcase
      end
   end

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // input sample register, payload only
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         x_ff <= req_tdata;
      end
   end

   // result register, payload only
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= y_in;
      end
   end

   // delay line and error feedback, updated as each sample leaves
   always_ff @(posedge clock) begin
      if (reset) begin
         x1_ff  <= '0;
         x2_ff  <= '0;
         y1_ff  <= '0;
         y2_ff  <= '0;
         err_ff <= '0;
      end else if (advance) begin
         x1_ff <= x_ff;
         x2_ff <= x1_ff;
         y1_ff <= y_in;
         y2_ff <= y1_ff;
         if (noise_shaping_ff) begin
            err_ff <= acc5[fpbq_pkg::ErrWidth-1:0];
         end
      end
   end

`ifndef SYNTHESIS
   // the fed-back output is the one just presented
   a_y1_matches_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> (y1_ff == rsp_data_ff))
      else $error("y1 does not match the last result");

   // the input delay takes the sample that was just filtered
   a_x1_tracks_input: assert property (@(posedge clock) disable iff (reset)
      advance |=> (x1_ff == $past(x_ff)))
      else $error("x1 does not follow the filtered sample");

   // error feedback is frozen while noise shaping is off
   a_err_frozen: assert property (@(posedge clock) disable iff (reset)
      (advance && !noise_shaping_ff) |=> $stable(err_ff))
      else $error("truncation error changed with noise shaping off");

   // backpressure only when both stages are full and the result is stalled
   a_ready_low_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && rsp_valid_ff && !rsp_tready))
      else $error("req_tready low without a full, stalled pipeline");
`endif

endmodule

`default_nettype wire
